/* design/sitda_pkg.sv */
package sitda_pkg;

	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned CHAR_W = 6;
	localparam logic [CHAR_W-1:0] CH_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

	// BCD digits, least significant first.
	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	// One double-dabble step: add 3 to every digit of five or more, then shift in a bit.
	function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
		bcd_t adj;
		bcd_t res;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			adj[d] = (bcd[d] >= 4'd5) ? bcd[d] + 4'd3 : bcd[d];
		end
		res[0] = {adj[0][2:0], bit_in};
		for (int d = 1; d < NUM_DIGITS; d++) begin
			res[d] = {adj[d][2:0], adj[d-1][3]};
		end
		return res;
	endfunction

endpackage

/* design/sitda_conv.sv */
// Binary to BCD conversion pipeline: one magnitude stage, then eight stages of four
// double-dabble steps each.
module sitda_conv import sitda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_neg,
	output bcd_t        out_bcd
);
	localparam int unsigned STAGES = 8;

	logic [STAGES:0]        vld_s1;
	logic [STAGES:0]        neg_s1;
	logic [STAGES:0][31:0]  bin_s1;
	bcd_t [STAGES:0]        bcd_s1;
	logic [STAGES:0]        adv;

	// A stage advances when it is empty or its word moves on.
	always_comb begin
		adv[STAGES] = !vld_s1[STAGES] || out_ready;
		for (int s = STAGES - 1; s >= 0; s--) begin
			adv[s] = !vld_s1[s] || adv[s+1];
		end
	end
	assign in_ready = adv[0];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else begin
			if (adv[0]) vld_s1[0] <= in_valid;
			for (int s = 1; s <= STAGES; s++) begin
				if (adv[s]) vld_s1[s] <= vld_s1[s-1];
			end
		end
	end

	// Payload: magnitude first, then four conversion steps per stage.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			neg_s1[0] <= in_value[31];
			bin_s1[0] <= in_value[31] ? 32'd0 - in_value : in_value;
			bcd_s1[0] <= '0;
		end
		for (int s = 1; s <= STAGES; s++) begin
			if (adv[s]) begin
				bcd_t b;
				b = bcd_s1[s-1];
				for (int k = 0; k < 4; k++) begin
					b = dabble_step(b, bin_s1[s-1][31-k]);
				end
				bcd_s1[s] <= b;
				bin_s1[s] <= {bin_s1[s-1][27:0], 4'd0};
				neg_s1[s] <= neg_s1[s-1];
			end
		end
	end

	assign out_valid = vld_s1[STAGES];
	assign out_neg   = neg_s1[STAGES];
	assign out_bcd   = bcd_s1[STAGES];

	a_no_bcd_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_bcd[NUM_DIGITS-1] <= 4'd4) else $error("top digit out of range");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bcd)) else $error("lost word");
	a_neg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1[0] && neg_s1[0] |-> bin_s1[0] != 32'd0)
		else $error("negative word with zero magnitude");
endmodule

/* design/sitda_emit.sv */
// Character sequencer: takes one BCD number and gives its sign and digits one per cycle while out_ready is high.
module sitda_emit import sitda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_neg,
	input  bcd_t              in_bcd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] char_code,
	output logic              last_char
);
	localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

	logic              busy_q;
	logic              sign_q;
	logic [IDX_W-1:0]  idx_q;
	bcd_t              bcd_q;
	logic [IDX_W-1:0]  top_idx;
	logic              done;

	// Index of the most significant non-zero digit, zero for the value zero.
	always_comb begin
		top_idx = '0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (in_bcd[d] != 4'd0) top_idx = IDX_W'(d);
		end
	end

	assign out_valid = busy_q;
	assign char_code = sign_q ? CH_MINUS : CH_ZERO + {2'b00, bcd_q[idx_q]};
	assign last_char = !sign_q && idx_q == '0;
	assign done      = busy_q && out_ready && last_char;
	assign in_ready  = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			sign_q <= in_neg;
			idx_q  <= top_idx;
		end else if (busy_q && out_ready) begin
			if (done) busy_q <= 1'b0;
			else if (sign_q) sign_q <= 1'b0;
			else idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) bcd_q <= in_bcd;
	end

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < IDX_W'(NUM_DIGITS)) else $error("digit index out of range");
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !sign_q && out_ready && !last_char |=> !sign_q) else $error("sign late");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !sign_q |-> bcd_q[idx_q] <= 4'd9) else $error("bad digit");
endmodule

/* design/signed_int_to_decimal_ascii_unit.sv */
// Renders a signed 32-bit value as decimal ASCII, one character per output word: a
// leading '-' for negative values, then digits most significant first without leading
// zeros; the final character has last_char set. A number gives 1 to 11 characters;
// conversion is a nine-stage pipeline ahead of the character sequencer, so further
// numbers convert while earlier ones are being emitted.
module signed_int_to_decimal_ascii_unit import sitda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [31:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        char_code,
	output logic              last_char
);
	logic c_valid;
	logic c_ready;
	logic c_neg;
	bcd_t c_bcd;

	sitda_conv u_conv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_value(value),
		.out_valid(c_valid), .out_ready(c_ready), .out_neg(c_neg), .out_bcd(c_bcd)
	);

	sitda_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c_valid), .in_ready(c_ready), .in_neg(c_neg), .in_bcd(c_bcd),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_code(char_code), .last_char(last_char)
	);
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import sitda_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_word_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic signed [31:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [5:0]        char_code;
	logic              last_char;

	logic signed [31:0] pending_values[$];
	char_word_t         expected_chars[$];
	int                 error_count;
	int                 send_gap;
	int                 recv_gap;
	bit                 stimulus_done;

	signed_int_to_decimal_ascii_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_code(char_code), .last_char(last_char)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("tb: mismatch: %s", what);
		error_count++;
	endtask

	// Append the decimal text of one number to the expected characters.
	function automatic void predict_text(input logic [31:0] raw);
		logic        neg;
		logic [31:0] mag;
		logic [3:0]  digs[10];
		int          nd;
		char_word_t  w;
		neg = raw[31];
		mag = neg ? (32'd0 - raw) : raw;
		nd = 0;
		do begin
			digs[nd] = 4'(mag % 10);
			mag = mag / 10;
			nd++;
		end while (mag != 0 && nd < NUM_DIGITS);
		if (neg) begin
			w.code = CH_MINUS;
			w.last = 1'b0;
			expected_chars.push_back(w);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			w.code = CH_ZERO + CHAR_W'(digs[i]);
			w.last = (i == 0);
			expected_chars.push_back(w);
		end
	endfunction

	// Driver: presents queued words, predicting each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_text(value);
			end
			if (in_valid && !in_ready) begin
				// Hold the word until it is taken.
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_values.size() > 0) begin
				in_valid <= 1'b1;
				value <= pending_values.pop_front();
				send_gap <= (pending_values.size() % 60 < 20) ? 0 : $urandom_range(0, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each accepted character against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		char_word_t exp_w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char %0d", char_code));
				end else begin
					exp_w = expected_chars.pop_front();
					if (char_code !== exp_w.code)
						report_mismatch($sformatf("char_code %0d, wanted %0d",
							char_code, exp_w.code));
					if (last_char !== exp_w.last)
						report_mismatch($sformatf("last_char %0b, wanted %0b",
							last_char, exp_w.last));
				end
			end
			if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic signed [31:0] directed[] = '{
			0, 1, -1, 9, 10, -10, 99, 100, 2147483647, -2147483648,
			-2147483647, 1000000000, 999999999, -999999999, 32'h55555555,
			32'hAAAAAAAA, 1234567890, -1234567890, 5, -9};
		int k;
		error_count = 0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		foreach (directed[i]) pending_values.push_back(directed[i]);
		for (int i = 0; i < 310; i++) begin
			k = $urandom_range(0, 3);
			case (k)
				0: pending_values.push_back($urandom());
				1: pending_values.push_back($signed(32'($urandom_range(0, 999))) *
					($urandom_range(0, 1) ? 1 : -1));
				2: pending_values.push_back($signed($urandom()) >>> $urandom_range(0, 31));
				default: pending_values.push_back($urandom() | 32'h80000000);
			endcase
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_values.size() == 0 && !in_valid);
		wait (expected_chars.size() == 0);
		repeat (30) @(posedge clk);
		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
design/sitda_pkg.sv
design/sitda_conv.sv
design/sitda_emit.sv
design/signed_int_to_decimal_ascii_unit.sv
dv/tb.sv
